// ===== src/eprq_pkg.sv =====
// ----------------------------------------------------------------------------
// eprq_pkg: shared types and constants for the endpoint packet ring queues
// Holds sizes, status and function codes, FSM states and the ctrl/dp structs.
// ----------------------------------------------------------------------------
`default_nettype none
package eprq_pkg;
  localparam int unsigned NumEp      = 10;
  localparam int unsigned RingSlots  = 4;
  localparam int unsigned PktBytes   = 1024;
  localparam int unsigned EpW        = $clog2(NumEp);
  localparam int unsigned SlotW      = $clog2(RingSlots);
  localparam int unsigned FillW      = $clog2(RingSlots + 1);
  localparam int unsigned PosW       = $clog2(PktBytes);
  localparam int unsigned LenW       = 11;
  localparam int unsigned StoreDepth = NumEp * RingSlots * PktBytes;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StArg   = 3'd1;
  localparam logic [2:0] StState = 3'd2;
  localparam logic [2:0] StFull  = 3'd3;
  localparam logic [2:0] StEmpty = 3'd4;

  localparam logic [1:0] FnOpen  = 2'd0;
  localparam logic [1:0] FnSend  = 2'd1;
  localparam logic [1:0] FnRecv  = 2'd2;
  localparam logic [1:0] FnClear = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // run the operation, update state, load result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_busy; // result word is held
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== src/eprq_datapath.sv =====
// ----------------------------------------------------------------------------
// eprq_datapath: endpoint tables, transfer registers and packet memory
// Stage 1 captures the word and reads the memory; stage 2 updates state.
// ----------------------------------------------------------------------------
`default_nettype none
module eprq_datapath import eprq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dp_cmd_t         cmd_i,
  output dp_sts_t              sts_o,
  input  wire logic            enabled_i,
  input  wire logic [1:0]      func_i,
  input  wire logic [3:0]      ep_index_i,
  input  wire logic            ep_dir_i,
  input  wire logic [1:0]      ep_kind_i,
  input  wire logic [10:0]     max_packet_size_i,
  input  wire logic [10:0]     pkt_length_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic [10:0]     buf_limit_i,
  input  wire logic            res_take_i,
  output logic [2:0]           status_o,
  output logic [7:0]           rx_byte_o,
  output logic                 byte_valid_o,
  output logic                 last_byte_o,
  output logic [10:0]          rx_count_o,
  output logic                 ep_in_event_o
);
  // endpoint tables
  logic             open_q   [NumEp];
  logic             dir_q    [NumEp];
  logic [1:0]       kind_q   [NumEp];
  logic [LenW-1:0]  maxb_q   [NumEp];
  logic [SlotW-1:0] head_q   [NumEp];
  logic [SlotW-1:0] tail_q   [NumEp];
  logic [FillW-1:0] fill_q   [NumEp];
  // slot lengths: written on commit, read on every capture, used only for a filled head slot
  logic [LenW-1:0]  slen_q   [NumEp][RingSlots];

  // transfer state
  logic [1:0]       act_q;       // 0 none, else FnSend/FnRecv
  logic [EpW-1:0]   aep_q;
  logic [LenW-1:0]  pos_q, tot_q;
  logic             rej_q;
  logic [2:0]       xst_q;

  // captured word
  logic [1:0]  f_q;
  logic [3:0]  ep_q;
  logic        d_q;
  logic [1:0]  k_q;
  logic [10:0] mps_q, len_q, lim_q;
  logic [7:0]  db_q;

  // result word
  logic        res_v_q;
  logic [2:0]  st_q;
  logic [7:0]  rb_q;
  logic        bv_q, lb_q, ev_q;
  logic [10:0] rc_q;

  logic [7:0]      mem [StoreDepth];
  logic [7:0]      rd_q;
  logic [LenW-1:0] plen_q;

  // memory read address for a receive item, from the live word
  logic             cont_rx;
  logic [EpW-1:0]   rep;
  logic [PosW-1:0]  rpos;
  logic [AddrW-1:0] raddr;
  always_comb begin
    cont_rx = (act_q == FnRecv) && (func_i == FnRecv);
    rep     = cont_rx ? aep_q : EpW'(ep_index_i - 4'd1);
    rpos    = cont_rx ? pos_q[PosW-1:0] : '0;
    raddr   = AddrW'((AddrW'(rep) * AddrW'(RingSlots) + AddrW'(head_q[rep]))
              * AddrW'(PktBytes) + AddrW'(rpos));
  end

  // capture, packet memory and head slot length read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q <= func_i; ep_q <= ep_index_i; d_q <= ep_dir_i; k_q <= ep_kind_i;
      mps_q <= max_packet_size_i; len_q <= pkt_length_i;
      db_q <= data_byte_i; lim_q <= buf_limit_i;
      rd_q <= mem[raddr];
      plen_q <= slen_q[rep][head_q[rep]];
    end
  end

  // operation decode on captured word
  logic             active, idx_ok;
  logic [EpW-1:0]   e_new, e;
  logic [2:0]       st;
  logic [LenW-1:0]  tot, pos;
  logic             rej, last, wr_en, sv_commit, rx_go, rx_last;
  logic [AddrW-1:0] waddr;
  always_comb begin
    active  = (act_q != 2'd0) && (act_q == f_q);
    idx_ok  = (ep_q != 4'd0) && (ep_q <= 4'(NumEp));
    e_new   = idx_ok ? EpW'(ep_q - 4'd1) : '0;
    e       = active ? aep_q : e_new;
    st      = StOk;
    tot     = tot_q;
    pos     = active ? pos_q : '0;
    rej     = rej_q;
    last    = 1'b0;
    wr_en   = 1'b0;
    sv_commit = 1'b0;
    rx_go   = 1'b0;
    rx_last = 1'b0;
    if (f_q == FnSend) begin
      if (!active) begin
        if (!enabled_i) st = StState;
        else if (!idx_ok || len_q > 11'(PktBytes)) st = StArg;
        else if (!open_q[e_new]) st = StState;
        else if (len_q > maxb_q[e_new]) st = StArg;
        else if (fill_q[e_new] >= FillW'(RingSlots)) st = StFull;
        tot = len_q;
        rej = (st != StOk);
      end else begin
        st = xst_q;
      end
      wr_en     = !rej && (pos < tot);
      last      = (12'(pos) + 12'd1) >= ((tot == '0) ? 12'd1 : 12'(tot));
      sv_commit = last && !rej;
    end else if (f_q == FnRecv) begin
      if (!active) begin
        if (!enabled_i) st = StState;
        else if (!idx_ok || lim_q == 11'd0) st = StArg;
        else if (!open_q[e_new]) st = StState;
        else if (fill_q[e_new] == '0) st = StEmpty;
        tot = (plen_q < lim_q) ? plen_q : lim_q;
      end
      rx_go   = (st == StOk);
      rx_last = rx_go && ((12'(pos) + 12'd1) >= 12'(tot));
    end
    waddr = AddrW'((AddrW'(e) * AddrW'(RingSlots) + AddrW'(tail_q[e]))
            * AddrW'(PktBytes) + AddrW'(pos[PosW-1:0]));
  end

  // packet memory write
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && f_q == FnSend && wr_en) mem[waddr] <= db_q;
  end

  // slot length write on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && f_q == FnSend && sv_commit) slen_q[e][tail_q[e]] <= tot;
  end

  // state and result update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEp; i++) begin
        open_q[i] <= 1'b0; dir_q[i] <= 1'b0; kind_q[i] <= '0; maxb_q[i] <= '0;
        head_q[i] <= '0; tail_q[i] <= '0; fill_q[i] <= '0;
      end
      act_q <= '0; aep_q <= '0; pos_q <= '0; tot_q <= '0; rej_q <= 1'b0;
      xst_q <= StOk; res_v_q <= 1'b0;
      st_q <= StOk; rb_q <= '0; bv_q <= 1'b0; lb_q <= 1'b0; rc_q <= '0; ev_q <= 1'b0;
    end else begin
      if (res_take_i) res_v_q <= 1'b0;
      if (cmd_i.exec) begin
        res_v_q <= 1'b1;
        st_q <= StOk; rb_q <= '0; bv_q <= 1'b0; lb_q <= 1'b0; rc_q <= '0;
        ev_q <= 1'b0;
        if (!active) begin
          act_q <= '0; pos_q <= '0; tot_q <= '0; rej_q <= 1'b0; xst_q <= StOk;
        end
        unique case (f_q)
          FnOpen: begin
            lb_q <= 1'b1;
            if (!enabled_i) st_q <= StState;
            else if (!idx_ok || mps_q == 11'd0 || mps_q > 11'(PktBytes)) st_q <= StArg;
            else begin
              open_q[e_new] <= 1'b1; dir_q[e_new] <= d_q; kind_q[e_new] <= k_q;
              maxb_q[e_new] <= mps_q; head_q[e_new] <= '0; tail_q[e_new] <= '0;
              fill_q[e_new] <= '0;
            end
          end
          FnClear: begin
            lb_q <= 1'b1;
            if (!enabled_i) st_q <= StState;
            else begin
              for (int i = 0; i < NumEp; i++) begin
                open_q[i] <= 1'b0; dir_q[i] <= 1'b0; kind_q[i] <= '0;
                maxb_q[i] <= '0; head_q[i] <= '0; tail_q[i] <= '0; fill_q[i] <= '0;
              end
            end
          end
          FnSend: begin
            st_q <= st;
            if (last) begin
              lb_q <= 1'b1;
              act_q <= '0; pos_q <= '0; tot_q <= '0; rej_q <= 1'b0; xst_q <= StOk;
              if (sv_commit) begin
                tail_q[e] <= SlotW'(tail_q[e] + SlotW'(1));
                fill_q[e] <= fill_q[e] + FillW'(1);
                ev_q <= 1'b1;
              end
            end else begin
              act_q <= FnSend; aep_q <= e; tot_q <= tot; rej_q <= rej; xst_q <= st;
              pos_q <= pos + 11'd1;
            end
          end
          FnRecv: begin
            if (!rx_go) begin
              st_q <= st; lb_q <= 1'b1;
            end else begin
              if (tot != '0) begin
                rb_q <= rd_q; bv_q <= 1'b1;
              end
              if (rx_last) begin
                lb_q <= 1'b1; rc_q <= tot;
                head_q[e] <= SlotW'(head_q[e] + SlotW'(1));
                fill_q[e] <= fill_q[e] - FillW'(1);
                act_q <= '0; pos_q <= '0; tot_q <= '0;
              end else begin
                act_q <= FnRecv; aep_q <= e; tot_q <= tot; pos_q <= pos + 11'd1;
                rej_q <= 1'b0; xst_q <= StOk;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign sts_o.res_busy = res_v_q;
  assign status_o      = st_q;
  assign rx_byte_o     = rb_q;
  assign byte_valid_o  = bv_q;
  assign last_byte_o   = lb_q;
  assign rx_count_o    = rc_q;
  assign ep_in_event_o = ev_q;
endmodule
`default_nettype wire

// ===== src/eprq_ctrl.sv =====
// ----------------------------------------------------------------------------
// eprq_ctrl: sequencing of one word through capture and execute
// Accepts a word, executes it once the result slot is free.
// ----------------------------------------------------------------------------
`default_nettype none
module eprq_ctrl import eprq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts_i,
  input  wire logic    res_take_i,
  output dp_cmd_t      cmd_o
);
  state_e state_q, state_d;
  logic   slot_free;

  assign slot_free = !sts_i.res_busy || res_take_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid) state_d = S_EXEC;
      S_EXEC: if (slot_free) state_d = S_IDLE;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      S_EXEC: cmd_o.exec = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== src/endpoint_packet_ring_queues.sv =====
// ----------------------------------------------------------------------------
// endpoint_packet_ring_queues: per-endpoint rings of packet slots
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word per item (func, index,
//   open settings, send length and byte, receive limit). Output channel
//   out_valid/out_ready returns exactly one result word per input word.
//   cfg_valid/cfg_ready writes block_enabled; write it only while idle.
// Timing:
//   A word is captured (packet memory read) in the idle state and executed
//   in the execute state; the result is registered. A new word is taken
//   only in the idle state, so the block takes no new word before the last
//   has been executed; the packet memory read comes before the state update.
//   The next word is taken while a result still waits to be read; execution
//   holds only if the result register is still full.
// Reset:
//   All endpoints closed, rings empty, block disabled, no transfer active.
//   Packet memory is not cleared; only bytes written by a send are delivered.
// Stall:
//   With out_ready low one result is held and one further word waits.
// ----------------------------------------------------------------------------
`default_nettype none
module endpoint_packet_ring_queues import eprq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  ep_index_i,
  input  wire logic        ep_dir_i,
  input  wire logic [1:0]  ep_kind_i,
  input  wire logic [10:0] max_packet_size_i,
  input  wire logic [10:0] pkt_length_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [10:0] buf_limit_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status_o,
  output logic [7:0]       rx_byte_o,
  output logic             byte_valid_o,
  output logic             last_byte_o,
  output logic [10:0]      rx_count_o,
  output logic             ep_in_event_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    enabled_q;
  logic    take;

  assign cfg_ready = 1'b1;
  assign take      = out_valid && out_ready;
  assign out_valid = sts.res_busy;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) enabled_q <= 1'b0;
    else if (cfg_valid) enabled_q <= cfg_data_i;
  end

  eprq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .sts_i(sts), .res_take_i(take), .cmd_o(cmd)
  );

  eprq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .enabled_i(enabled_q),
    .func_i, .ep_index_i, .ep_dir_i, .ep_kind_i, .max_packet_size_i,
    .pkt_length_i, .data_byte_i, .buf_limit_i, .res_take_i(take),
    .status_o, .rx_byte_o, .byte_valid_o, .last_byte_o, .rx_count_o,
    .ep_in_event_o
  );
endmodule
`default_nettype wire

// ===== src/eprq_checker.sv =====
// ----------------------------------------------------------------------------
// eprq_checker: port-level checks for the ring queue block
// Watches handshakes and result words; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module eprq_checker import eprq_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status_o,
  input wire logic        byte_valid_o,
  input wire logic        last_byte_o,
  input wire logic [10:0] rx_count_o,
  input wire logic        ep_in_event_o
);
  // result status holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status_o))
    else $error("result changed while stalled");

  // a fresh result follows an accepted word that has passed capture and execute
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without input");

  // commit event only on a clean final word
  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && ep_in_event_o |-> last_byte_o && status_o == StOk)
    else $error("bad commit event");

  // delivery count only on a final word
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rx_count_o != 11'd0 |-> last_byte_o && byte_valid_o)
    else $error("count on non-final word");
endmodule

bind endpoint_packet_ring_queues eprq_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
  .status_o, .byte_valid_o, .last_byte_o, .rx_count_o, .ep_in_event_o
);
`default_nettype wire
